// ===== design/npg_pkg.sv =====
// Package for the next prime generator: field widths, constants, micro-op codes
// and the microcode program that drives the sequencer.
// Depends on nothing; used by the response channel interface, the top level and the testbench.
package npg_pkg;

   localparam int VALUE_WIDTH       = 16;
   localparam int FIRST_CANDIDATE   = 3;
   localparam int FIRST_DIVISOR     = 2;
   localparam int UPPER_LIMIT_RESET = 100;
   localparam int PC_BITS           = 4;

   typedef logic [PC_BITS-1:0] pc_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_D_INIT,
      OP_REM_INIT,
      OP_REM_STEP,
      OP_C_NEXT,
      OP_EMIT_PRIME,
      OP_EMIT_DONE
   } uop_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NEVER,
      COND_NO_REQ,
      COND_C_GE_LIMIT,
      COND_SQ_GT_C,
      COND_MORE_BITS,
      COND_REM_NZ,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   // Program step addresses.
   localparam pc_type STEP_WAIT     = 4'd0;
   localparam pc_type STEP_LIMIT    = 4'd1;
   localparam pc_type STEP_DINIT    = 4'd2;
   localparam pc_type STEP_SQTEST   = 4'd3;
   localparam pc_type STEP_RINIT    = 4'd4;
   localparam pc_type STEP_RSTEP    = 4'd5;
   localparam pc_type STEP_RTEST    = 4'd6;
   localparam pc_type STEP_CNEXT    = 4'd7;
   localparam pc_type STEP_PRIME    = 4'd8;
   localparam pc_type STEP_PRET     = 4'd9;
   localparam pc_type STEP_DONE     = 4'd10;
   localparam pc_type STEP_DRET     = 4'd11;
   localparam pc_type STEP_DNEXT    = 4'd12;

   // Control store. When the condition holds the sequencer jumps to the target,
   // otherwise it falls through to the next step.
   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_WAIT};
      case (pc)
         STEP_WAIT:   w = '{op: OP_LOAD,       cond: COND_NO_REQ,     target: STEP_WAIT};
         STEP_LIMIT:  w = '{op: OP_NONE,       cond: COND_C_GE_LIMIT, target: STEP_DONE};
         STEP_DINIT:  w = '{op: OP_D_INIT,     cond: COND_NEVER,      target: STEP_WAIT};
         STEP_SQTEST: w = '{op: OP_NONE,       cond: COND_SQ_GT_C,    target: STEP_PRIME};
         STEP_RINIT:  w = '{op: OP_REM_INIT,   cond: COND_NEVER,      target: STEP_WAIT};
         STEP_RSTEP:  w = '{op: OP_REM_STEP,   cond: COND_MORE_BITS,  target: STEP_RSTEP};
         STEP_RTEST:  w = '{op: OP_NONE,       cond: COND_REM_NZ,     target: STEP_DNEXT};
         STEP_CNEXT:  w = '{op: OP_C_NEXT,     cond: COND_ALWAYS,     target: STEP_LIMIT};
         STEP_PRIME:  w = '{op: OP_EMIT_PRIME, cond: COND_OUT_BUSY,   target: STEP_PRIME};
         STEP_PRET:   w = '{op: OP_NONE,       cond: COND_ALWAYS,     target: STEP_WAIT};
         STEP_DONE:   w = '{op: OP_EMIT_DONE,  cond: COND_OUT_BUSY,   target: STEP_DONE};
         STEP_DRET:   w = '{op: OP_NONE,       cond: COND_ALWAYS,     target: STEP_WAIT};
         STEP_DNEXT:  w = '{op: OP_NONE,       cond: COND_ALWAYS,     target: STEP_SQTEST};
         default:     w = '{op: OP_NONE,       cond: COND_ALWAYS,     target: STEP_WAIT};
      endcase
      // The divisor advance shares its word with the jump back to the square test.
      if (pc == STEP_DNEXT) begin
         w.op = OP_REM_STEP;
      end
      return w;
   endfunction

endpackage

// ===== design/npg_req_if.sv =====
// Request channel of the next prime generator: valid/ready plus the restart flag.
// Depends on nothing.
interface npg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// ===== design/npg_rsp_if.sv =====
// Response channel of the next prime generator: valid/ready plus the result fields.
// Depends on npg_pkg for the value width.
interface npg_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [npg_pkg::VALUE_WIDTH-1:0]  prime_value;
   logic                             done_res;

   modport source (output valid, output prime_value, output done_res, input ready);
   modport sink   (input valid, input prime_value, input done_res, output ready);
endinterface

// ===== design/next_prime_generator_unit.sv =====
// Top level of the next prime generator: microcoded sequencer over a trial
// division datapath with a bit-serial remainder unit.
// Depends on npg_pkg, npg_req_if and npg_rsp_if.
//
//   channel    direction  handshake            payload
//   req_chan   in         valid / ready        restart
//   rsp_chan   out        valid / ready        prime_value, done_res
//   csr_       in         csr_write_en         csr_upper_limit
//
// A request is taken at the wait step. Each odd candidate passes the limit check
// and the divisor init, then per trial divisor the square test, remainder init,
// bit-serial remainder loop, remainder test and divisor advance. A prime ends with
// its final square test and its emit step; a done request goes from the limit check to its emit step.
// The response register frees the sequencer to take the next request while
// a result waits; a new result waits at its emit step until the slot is free.
// Reset (synchronous, active high) sets the candidate to 3 and the limit to 100.
module next_prime_generator_unit #(
   parameter int VALUE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   npg_req_if.sink                         req_chan,
   npg_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [npg_pkg::VALUE_WIDTH-1:0] csr_upper_limit
);

   localparam int FIELD_BITS = npg_pkg::VALUE_WIDTH;
   localparam int LIMIT_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
   localparam int CAND_BITS  = LIMIT_BITS + 1;
   localparam int CNT_BITS   = $clog2(CAND_BITS + 1);

   npg_pkg::pc_type          pc_ff, pc_in;
   npg_pkg::uword_type       uword;
   logic                     cond_true;
   logic                     out_busy;

   logic [LIMIT_BITS-1:0]    limit_ff, limit_in;
   logic [CAND_BITS-1:0]     cand_ff, cand_in;
   logic [CAND_BITS-1:0]     c_ff, c_in;
   logic [CAND_BITS-1:0]     d_ff, d_in;
   logic [CAND_BITS-1:0]     sq_ff, sq_in;
   logic [CAND_BITS-1:0]     rem_ff, rem_in;
   logic [CAND_BITS-1:0]     dvd_ff, dvd_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [CAND_BITS:0]       rem_shift;
   logic [CAND_BITS:0]       rem_diff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0]    prime_ff, prime_in;
   logic                     done_ff, done_in;

   assign uword    = npg_pkg::ucode_rom(pc_ff);
   assign out_busy = rsp_valid_ff && !rsp_chan.ready;

   assign rem_shift = {rem_ff, dvd_ff[CAND_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, d_ff};

   always_comb begin
      case (uword.cond)
         npg_pkg::COND_ALWAYS:     cond_true = 1'b1;
         npg_pkg::COND_NEVER:      cond_true = 1'b0;
         npg_pkg::COND_NO_REQ:     cond_true = !req_chan.valid;
         npg_pkg::COND_C_GE_LIMIT: cond_true = c_ff >= {1'b0, limit_ff};
         npg_pkg::COND_SQ_GT_C:    cond_true = sq_ff > c_ff;
         npg_pkg::COND_MORE_BITS:  cond_true = cnt_ff != CNT_BITS'(1);
         npg_pkg::COND_REM_NZ:     cond_true = rem_ff != '0;
         npg_pkg::COND_OUT_BUSY:   cond_true = out_busy;
         default:                  cond_true = 1'b1;
      endcase
   end

   always_comb begin
      pc_in        = cond_true ? uword.target : pc_ff + npg_pkg::pc_type'(1);
      limit_in     = csr_write_en ? csr_upper_limit[LIMIT_BITS-1:0] : limit_ff;
      cand_in      = cand_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      prime_in     = prime_ff;
      done_in      = done_ff;

      case (uword.op)
         npg_pkg::OP_LOAD: begin
            if (req_chan.valid) begin
               c_in = req_chan.restart ? CAND_BITS'(npg_pkg::FIRST_CANDIDATE) : cand_ff;
            end
         end
         npg_pkg::OP_D_INIT: begin
            d_in  = CAND_BITS'(npg_pkg::FIRST_DIVISOR);
            sq_in = CAND_BITS'(npg_pkg::FIRST_DIVISOR * npg_pkg::FIRST_DIVISOR);
         end
         npg_pkg::OP_REM_INIT: begin
            rem_in = '0;
            dvd_in = c_ff;
            cnt_in = CNT_BITS'(CAND_BITS);
         end
         npg_pkg::OP_REM_STEP: begin
            if (pc_ff == npg_pkg::STEP_DNEXT) begin
               // Next divisor: (d+1)^2 = d^2 + 2d + 1.
               d_in  = d_ff + CAND_BITS'(1);
               sq_in = sq_ff + {d_ff[CAND_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_diff[CAND_BITS] ? rem_shift[CAND_BITS-1:0]
                                            : rem_diff[CAND_BITS-1:0];
               dvd_in = {dvd_ff[CAND_BITS-2:0], 1'b0};
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         npg_pkg::OP_C_NEXT: begin
            c_in = c_ff + CAND_BITS'(2);
         end
         npg_pkg::OP_EMIT_PRIME: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               prime_in     = FIELD_BITS'(c_ff[LIMIT_BITS-1:0]);
               done_in      = 1'b0;
               cand_in      = c_ff + CAND_BITS'(2);
            end
         end
         npg_pkg::OP_EMIT_DONE: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               prime_in     = '0;
               done_in      = 1'b1;
               // The walk stops at the first odd value at or above the limit,
               // or stays put when the start was already there.
               cand_in      = c_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= npg_pkg::STEP_WAIT;
         limit_ff     <= LIMIT_BITS'(npg_pkg::UPPER_LIMIT_RESET);
         cand_ff      <= CAND_BITS'(npg_pkg::FIRST_CANDIDATE);
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         limit_ff     <= limit_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff     <= c_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
      done_ff  <= done_in;
   end

   assign req_chan.ready       = (pc_ff == npg_pkg::STEP_WAIT);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.prime_value = prime_ff;
   assign rsp_chan.done_res    = done_ff;

   // A taken request always moves the sequencer on to the limit check.
   a_accept_advances: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (pc_ff == npg_pkg::STEP_LIMIT))
      else $error("request accepted but sequencer did not advance");

   // The held candidate is always odd.
   a_cand_odd: assert property (@(posedge clock) disable iff (reset)
      cand_ff[0])
      else $error("held candidate became even");

   // The partial remainder stays below the divisor while dividing.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == npg_pkg::STEP_RSTEP) |-> (rem_ff < d_ff))
      else $error("partial remainder not below divisor");

   // A done response carries zero, and a prime response an odd value.
   a_rsp_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (done_ff ? (prime_ff == '0) : prime_ff[0]))
      else $error("malformed response");

   // A prime is only reported once the square of the divisor exceeds it.
   a_prime_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == npg_pkg::STEP_PRIME) |-> (sq_ff > c_ff) && (c_ff < {1'b0, limit_ff}))
      else $error("prime reported before trial division finished");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for next_prime_generator_unit: predicts each response by trial division
// and checks it field by field. Depends on npg_pkg, npg_req_if and npg_rsp_if.
module tb;
   localparam int VALUE_WIDTH       = npg_pkg::VALUE_WIDTH;
   localparam int FIRST_CANDIDATE   = npg_pkg::FIRST_CANDIDATE;
   localparam int FIRST_DIVISOR     = npg_pkg::FIRST_DIVISOR;
   localparam int UPPER_LIMIT_RESET = npg_pkg::UPPER_LIMIT_RESET;
   localparam int CAND_WIDTH        = VALUE_WIDTH + 1;

   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 50;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 15;

   localparam int IDLE_NONE = 0;
   localparam int IDLE_HIGH = 54;
   localparam int IDLE_BOTH = 31;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] prime_value;
      logic                   done_res;
   } prime_result_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [VALUE_WIDTH-1:0] csr_upper_limit;

   npg_req_if req_if ();
   npg_rsp_if rsp_if ();

   next_prime_generator_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_if),
      .rsp_chan        (rsp_if),
      .csr_write_en    (csr_write_en),
      .csr_upper_limit (csr_upper_limit)
   );

   // Predictor state: the limit as last written and the next odd candidate.
   logic [VALUE_WIDTH-1:0] limit_model;
   logic [VALUE_WIDTH:0]   cand_model;

   logic             pending_restarts[$];
   prime_result_type expected_primes[$];
   int               sender_gap_pct;
   int               receiver_stall_pct;
   int               error_count;
   int               cycle_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit no_trial_divisor(input int unsigned c);
      int unsigned d;
      for (d = FIRST_DIVISOR; d * d <= c; d++) begin
         if (c % d == 0) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   task automatic predict_next_prime(input logic restart);
      int unsigned      c;
      prime_result_type r;
      if (restart) begin
         cand_model = CAND_WIDTH'(FIRST_CANDIDATE);
      end
      c = 32'(cand_model);
      r.prime_value = '0;
      r.done_res    = 1'b1;
      while (r.done_res && c < limit_model) begin
         if (no_trial_divisor(c)) begin
            r.prime_value = c[VALUE_WIDTH-1:0];
            r.done_res    = 1'b0;
            cand_model    = CAND_WIDTH'(c + 2);
         end else begin
            c += 2;
         end
      end
      // An exhausted search leaves the candidate alone only if it already sat at or above the limit.
      if (r.done_res && cand_model < limit_model) begin
         cand_model = CAND_WIDTH'(c);
      end
      expected_primes.push_back(r);
   endtask

   always @(posedge clock) begin : request_driver
      logic launch;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.restart <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_next_prime(req_if.restart);
         end
         if (!req_if.valid || req_if.ready) begin
            launch = pending_restarts.size() != 0 && $urandom_range(99) >= sender_gap_pct;
            req_if.valid <= launch;
            if (launch) begin
               req_if.restart <= pending_restarts.pop_front();
            end
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      prime_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_primes.size() == 0) begin
               $error("unexpected response: prime_value %0d done_res %0b",
                      rsp_if.prime_value, rsp_if.done_res);
               error_count++;
            end else begin
               want = expected_primes.pop_front();
               if (rsp_if.prime_value !== want.prime_value) begin
                  $error("prime_value: expected %0d, got %0d",
                         want.prime_value, rsp_if.prime_value);
                  error_count++;
               end
               if (rsp_if.done_res !== want.done_res) begin
                  $error("done_res: expected %0b, got %0b", want.done_res, rsp_if.done_res);
                  error_count++;
               end
            end
         end
         rsp_if.ready <= $urandom_range(99) >= receiver_stall_pct;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The limit changes only while nothing is in flight.
   task automatic write_limit(input logic [VALUE_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_en    <= 1'b1;
      csr_upper_limit <= value;
      limit_model = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_restarts.size() != 0 || req_if.valid || expected_primes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] pick_limit();
      case ($urandom_range(9))
         0:       return VALUE_WIDTH'($urandom_range(3));
         1:       return '1;
         2:       return VALUE_WIDTH'($urandom_range(65535));
         3:       return VALUE_WIDTH'($urandom_range(400, 1500));
         default: return VALUE_WIDTH'($urandom_range(5, 400));
      endcase
   endfunction

   initial begin
      int phase;
      clock              = 1'b0;
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_upper_limit    = '0;
      limit_model        = VALUE_WIDTH'(UPPER_LIMIT_RESET);
      cand_model         = CAND_WIDTH'(FIRST_CANDIDATE);
      sender_gap_pct     = IDLE_NONE;
      receiver_stall_pct = IDLE_NONE;
      error_count        = 0;
      cycle_count        = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default limit: plain continuation and a restart in the middle.
      pending_restarts = {1'b0, 1'b0, 1'b1, 1'b0};
      wait_idle();
      // A zero limit reports done with or without restart.
      write_limit(VALUE_WIDTH'(0));
      pending_restarts = {1'b0, 1'b1};
      wait_idle();
      // With a limit of three no prime can be produced.
      write_limit(VALUE_WIDTH'(3));
      pending_restarts = {1'b1};
      wait_idle();
      write_limit(VALUE_WIDTH'(4));
      pending_restarts = {1'b1, 1'b0};
      wait_idle();
      // Run to exhaustion; the squares 9 and 25 must be skipped.
      write_limit(VALUE_WIDTH'(30));
      repeat (9) pending_restarts.push_back(1'b0);
      wait_idle();
      // Limit lowered below the held candidate.
      write_limit(VALUE_WIDTH'(12));
      pending_restarts = {1'b0};
      wait_idle();
      // Limit raised after done: the search resumes where it stopped.
      write_limit('1);
      pending_restarts = {1'b0, 1'b0, 1'b1};
      wait_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_limit(pick_limit());
         case (phase % 4)
            0: begin
               sender_gap_pct     = IDLE_NONE;
               receiver_stall_pct = IDLE_NONE;
            end
            1: begin
               sender_gap_pct     = IDLE_HIGH;
               receiver_stall_pct = IDLE_NONE;
            end
            2: begin
               sender_gap_pct     = IDLE_NONE;
               receiver_stall_pct = IDLE_HIGH;
            end
            default: begin
               sender_gap_pct     = IDLE_BOTH;
               receiver_stall_pct = IDLE_BOTH;
            end
         endcase
         // Mostly continuation requests, so the candidate climbs toward the limit.
         repeat (PHASE_ITEMS) pending_restarts.push_back($urandom_range(9) == 0);
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_primes.size() != 0) begin
         $error("%0d responses never arrived", expected_primes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== next_prime_generator_unit.f =====
design/npg_pkg.sv
design/npg_req_if.sv
design/npg_rsp_if.sv
design/next_prime_generator_unit.sv
test/tb.sv
